/* sv/ogpw_pkg.sv */
// ----------------------------------------------------------------------------
// ogpw_pkg
// Shared types and constants for the Ogg page chain walker.
// ----------------------------------------------------------------------------
package ogpw_pkg;

    localparam int unsigned SPAN_W        = 33;
    localparam int unsigned PAGES_W       = 22;
    localparam int unsigned SUM_W         = 17;
    localparam int unsigned HDR_LEN       = 27;
    localparam int unsigned HDR_LAST      = HDR_LEN - 1;  // segment count byte
    localparam int unsigned MAGIC_LEN     = 5;            // "OggS" plus version
    localparam int unsigned MAX_PAGES_DEF = 4000000;

    localparam logic [SPAN_W-1:0] MAX_SPAN_RST = 33'h1_0000_0000;

    localparam logic [7:0] CHR_O = 8'h4F;
    localparam logic [7:0] CHR_G = 8'h67;
    localparam logic [7:0] CHR_S = 8'h53;
    localparam logic [7:0] VERSION_0 = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LACING  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       source_end;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [SPAN_W-1:0]  carved_length;
        logic [PAGES_W-1:0] page_count;
    } t_result;

    // Expected header byte at offsets 0..4
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = CHR_O;
            3'd1:    val = CHR_G;
            3'd2:    val = CHR_G;
            3'd3:    val = CHR_S;
            default: val = VERSION_0;
        endcase
        return val;
    endfunction

endpackage

/* sv/ogpw_in_if.sv */
// ----------------------------------------------------------------------------
// ogpw_in_if
// Byte request channel into the page chain walker.
// ----------------------------------------------------------------------------
interface ogpw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       source_end;

    modport source (output valid, output data_byte, output first_byte,
                    output source_end, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input source_end, output ready);
endinterface

/* sv/ogpw_out_if.sv */
// ----------------------------------------------------------------------------
// ogpw_out_if
// Result request channel out of the page chain walker.
// ----------------------------------------------------------------------------
interface ogpw_out_if;
    import ogpw_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [SPAN_W-1:0]  carved_length;
    logic [PAGES_W-1:0] page_count;

    modport source (output valid, output found, output carved_length,
                    output page_count, input ready);
    modport sink   (input valid, input found, input carved_length,
                    input page_count, output ready);
endinterface

/* sv/ogpw_walker.sv */
// ----------------------------------------------------------------------------
// ogpw_walker
// Per-byte page walk state, stop decision and result register.
// ----------------------------------------------------------------------------
module ogpw_walker #(
    parameter int unsigned MAX_PAGES = ogpw_pkg::MAX_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ogpw_pkg::SPAN_W-1:0]   i_max_span,
    input  logic                          i_item_valid,
    input  ogpw_pkg::t_item               i_item,
    output logic                          o_item_take,
    output logic                          o_res_valid,
    output ogpw_pkg::t_result             o_res,
    input  logic                          i_res_ready
);
    import ogpw_pkg::*;

    // walk state
    t_phase             r_ph,   n_ph;
    logic [SPAN_W-1:0]  r_le,   n_le;    // end of last counted page
    logic [PAGES_W-1:0] r_ps,   n_ps;
    logic [4:0]         r_hi,   n_hi;
    logic [7:0]         r_sl,   n_sl;
    logic [7:0]         r_st,   n_st;
    logic [SUM_W-1:0]   r_sum,  n_sum;

    // state as seen after an optional restart
    t_phase             e_ph;
    logic [SPAN_W-1:0]  e_le;
    logic [PAGES_W-1:0] e_ps;
    logic [4:0]         e_hi;
    logic [7:0]         e_sl, e_st;
    logic [SUM_W-1:0]   e_sum;

    logic [SUM_W-1:0]   lace_sum, size, cnt_sum;
    logic [SPAN_W:0]    span_ext, cnt_end;      // one spare bit for the carry
    logic [SPAN_W-1:0]  span_less_hdr;
    logic [7:0]         lace_sl, b;
    logic               count, fin, stop, emit, active, no_room;

    logic               r_out_valid, n_out_valid;
    t_result            r_res, n_res;

    assign b = i_item.data_byte;

    // next state
    always_comb begin
        e_ph = r_ph; e_le = r_le; e_ps = r_ps;
        e_hi = r_hi; e_sl = r_sl; e_st = r_st; e_sum = r_sum;
        if (i_item.first_byte) begin
            e_ph = PH_HEADER; e_le = '0; e_ps = '0;
            e_hi = '0; e_sl = '0; e_st = '0; e_sum = '0;
        end
        n_ph = e_ph; n_le = e_le; n_ps = e_ps;
        n_hi = e_hi; n_sl = e_sl; n_st = e_st; n_sum = e_sum;

        active        = i_item.first_byte || (r_ph != PH_IDLE);
        lace_sum      = e_sum + SUM_W'(b);
        lace_sl       = e_sl - 8'd1;
        stop          = 1'b0;
        count         = 1'b0;
        fin           = 1'b0;
        size          = SUM_W'(HDR_LEN);
        cnt_sum       = '0;
        span_ext      = {1'b0, i_max_span};
        span_less_hdr = i_max_span - SPAN_W'(HDR_LEN);

        if (i_item.first_byte && (i_max_span < SPAN_W'(HDR_LEN))) begin
            stop = 1'b1;
        end else begin
            case (e_ph)
                PH_HEADER: begin
                    if (e_hi == 5'(HDR_LAST)) begin
                        n_st  = b;
                        n_sl  = b;
                        n_sum = '0;
                        if (b == 8'd0) begin
                            count = 1'b1;
                        end else begin
                            n_ph = PH_LACING;
                        end
                    end else if ((e_hi < 5'(MAGIC_LEN)) && (b != magic_byte(e_hi[2:0]))) begin
                        stop = 1'b1;
                    end else begin
                        n_hi = e_hi + 5'd1;
                    end
                end
                PH_LACING: begin
                    n_sum = lace_sum;
                    n_sl  = lace_sl;
                    if (lace_sl == 8'd0) begin
                        count   = 1'b1;
                        size    = SUM_W'(HDR_LEN) + SUM_W'(e_st) + lace_sum;
                        cnt_sum = lace_sum;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum = e_sum - SUM_W'(1);
                    if (n_sum == '0) begin
                        fin = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        cnt_end = {1'b0, e_le} + (SPAN_W+1)'(size);

        if (count) begin
            if (cnt_end > span_ext) begin
                stop = 1'b1;
            end else begin
                n_le = cnt_end[SPAN_W-1:0];
                n_ps = e_ps + PAGES_W'(1);
                if (cnt_sum == '0) begin
                    fin = 1'b1;
                end else begin
                    n_ph = PH_PAYLOAD;
                end
            end
        end

        // another header must still fit: page end + 27 within max_span
        no_room = (i_max_span < SPAN_W'(HDR_LEN)) || (n_le > span_less_hdr);

        // page done: room for another header and below the page limit?
        if (fin) begin
            if ((n_ps >= PAGES_W'(MAX_PAGES)) || no_room) begin
                stop = 1'b1;
            end else begin
                n_ph = PH_HEADER;
                n_hi = '0;
            end
        end

        emit = active && (stop || i_item.source_end);
        if (emit) begin
            n_ph = PH_IDLE;
        end
    end

    // outputs
    always_comb begin
        o_item_take = i_item_valid && (!emit || !r_out_valid || i_res_ready);
        n_res.found         = (n_ps != '0);
        n_res.carved_length = n_le;
        n_res.page_count    = n_ps;
        if (o_item_take && emit) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_item_take) begin
                r_ph <= n_ph;
            end
        end
        if (o_item_take) begin
            r_le   <= n_le;
            r_ps   <= n_ps;
            r_hi   <= n_hi;
            r_sl   <= n_sl;
            r_st   <= n_st;
            r_sum  <= n_sum;
        end
        if (o_item_take && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    // ---- assertions ----
    a_found_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.found == (r_res.page_count != '0)))
        else $error("found flag disagrees with page count");

    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.found) |-> (r_res.carved_length >= SPAN_W'(HDR_LEN)))
        else $error("counted page shorter than a header");

    a_lacing_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_LACING) |-> (r_sl != '0))
        else $error("lacing phase with no segments left");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_PAYLOAD) |-> (r_sum != '0))
        else $error("payload phase with nothing left to skip");

    a_hdr_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_HEADER) |-> (r_hi <= 5'(HDR_LAST)))
        else $error("header index past segment count byte");

endmodule

/* sv/ogg_page_chain_walker_unit.sv */
// ----------------------------------------------------------------------------
// ogg_page_chain_walker_unit
// Walks a chain of Ogg pages in a byte stream and reports the carved span.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle unless stalled, no bubbles between walks.
// A byte flagged first_byte starts a walk (and abandons any walk in flight
// without a result). Each page header is checked for "OggS" and version 0,
// the lacing table is summed, and the page is counted once its table is in
// and it ends within max_span; payload bytes are only counted down. One
// result request (found, carved_length, page_count) goes out on the byte
// that stops the walk: header mismatch, oversized page, no room for another
// header, MAX_PAGES reached, or source_end. CRC is not checked.
// A byte is taken into the input register; the walker then updates its state
// from that register and, on a stopping byte, loads the result register,
// which drives o_out.valid. The rate is set by the walker's per-byte update
// (a 17-bit lacing add and a 34-bit page-end add and compare against
// max_span). A held result only stalls input when another result is due.
// max_span resets to 2^32 and is used from the next byte on; write it only
// while no request is in flight. No memories, no clearing pass after reset.
// ----------------------------------------------------------------------------
module ogg_page_chain_walker_unit #(
    parameter int unsigned MAX_PAGES = ogpw_pkg::MAX_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ogpw_pkg::SPAN_W-1:0]   i_cfg_wdata,
    ogpw_in_if.sink                       i_in,
    ogpw_out_if.source                    o_out
);
    import ogpw_pkg::*;

    // config register
    logic [SPAN_W-1:0] r_max_span;

    // input register
    logic    r_in_valid, n_in_valid;
    t_item   r_in_item;
    logic    in_take;

    // walker side
    logic    item_take;
    logic    res_valid;
    t_result res;

    // input stage refills whenever it is empty or drains this cycle
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || item_take;

    always_comb begin
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (item_take) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_span <= MAX_SPAN_RST;
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_max_span <= i_cfg_wdata;
            end
        end
        if (in_take) begin
            r_in_item.data_byte  <= i_in.data_byte;
            r_in_item.first_byte <= i_in.first_byte;
            r_in_item.source_end <= i_in.source_end;
        end
    end

    ogpw_walker #(
        .MAX_PAGES (MAX_PAGES)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_span   (r_max_span),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_item),
        .o_item_take  (item_take),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (o_out.ready)
    );

    assign o_out.valid         = res_valid;
    assign o_out.found         = res.found;
    assign o_out.carved_length = res.carved_length;
    assign o_out.page_count    = res.page_count;

endmodule

/* tb/ogpw_chain_checker.sv */
// ----------------------------------------------------------------------------
// ogpw_chain_checker
// Watches the byte and result channels of the page chain walker, predicts
// every result from the accepted byte requests and compares field by field.
// ----------------------------------------------------------------------------
module ogpw_chain_checker #(
    parameter int unsigned PAGE_LIMIT = ogpw_pkg::MAX_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ogpw_pkg::SPAN_W-1:0] i_cfg_wdata,
    ogpw_in_if                          i_req_mon,
    ogpw_out_if                         i_res_mon,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_found
);
    import ogpw_pkg::*;

    localparam logic [7:0] OGG_SIG [MAGIC_LEN] = '{CHR_O, CHR_G, CHR_G, CHR_S, VERSION_0};

    // walker state as the block should hold it
    logic [SPAN_W-1:0]  span_limit = MAX_SPAN_RST;
    logic [SPAN_W-1:0]  byte_pos;
    logic [SPAN_W-1:0]  page_end;
    t_phase             walk_phase = PH_IDLE;
    logic [4:0]         hdr_idx;
    logic [7:0]         segs_left;
    logic [7:0]         seg_total;
    logic [SUM_W-1:0]   lace_sum;
    logic [PAGES_W-1:0] page_tally;

    t_result walk_results_q[$];
    int      fail_total   = 0;
    int      result_total = 0;
    int      found_total  = 0;

    function automatic void expect_result(input t_result r);
        walk_results_q.insert(walk_results_q.size(), r);
    endfunction

    // page (and its payload) done: stop on page limit or no room for a header
    function automatic logic close_page();
        if (page_tally >= PAGES_W'(PAGE_LIMIT) ||
            ({1'b0, page_end} + (SPAN_W+1)'(HDR_LEN)) > {1'b0, span_limit})
            return 1'b1;
        walk_phase = PH_HEADER;
        hdr_idx    = '0;
        return 1'b0;
    endfunction

    function automatic logic count_page(input logic [17:0] size);
        if ({1'b0, page_end} + (SPAN_W+1)'(size) > {1'b0, span_limit})
            return 1'b1;
        page_end   = page_end + SPAN_W'(size);
        page_tally = page_tally + 1'b1;
        if (lace_sum == '0)
            return close_page();
        walk_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic t_result finish_walk();
        t_result res;
        res.found         = (page_tally != '0);
        res.carved_length = page_end;
        res.page_count    = page_tally;
        walk_phase        = PH_IDLE;
        return res;
    endfunction

    task automatic step_walker(input t_item req, output logic emit, output t_result res);
        logic stop;
        stop = 1'b0;
        emit = 1'b0;
        res  = '0;
        if (req.first_byte) begin
            byte_pos   = '0;
            page_end   = '0;
            page_tally = '0;
            hdr_idx    = '0;
            segs_left  = '0;
            seg_total  = '0;
            lace_sum   = '0;
            walk_phase = PH_HEADER;
            // span too short for even one header: empty result right away
            if (span_limit < SPAN_W'(HDR_LEN)) begin
                res  = finish_walk();
                emit = 1'b1;
                return;
            end
        end else if (walk_phase == PH_IDLE) begin
            return;
        end

        case (walk_phase)
            PH_HEADER: begin
                if (hdr_idx == 5'(HDR_LAST)) begin
                    seg_total = req.data_byte;
                    segs_left = req.data_byte;
                    lace_sum  = '0;
                    if (req.data_byte == 8'd0)
                        stop = count_page(18'(HDR_LEN));
                    else
                        walk_phase = PH_LACING;
                end else if (hdr_idx < 5'(MAGIC_LEN) &&
                             req.data_byte != OGG_SIG[hdr_idx[2:0]]) begin
                    stop = 1'b1;
                end else begin
                    hdr_idx = hdr_idx + 1'b1;
                end
            end
            PH_LACING: begin
                lace_sum  = lace_sum + SUM_W'(req.data_byte);
                segs_left = segs_left - 1'b1;
                if (segs_left == '0)
                    stop = count_page(18'(HDR_LEN + seg_total + lace_sum));
            end
            default: begin
                lace_sum = lace_sum - 1'b1;
                if (lace_sum == '0)
                    stop = close_page();
            end
        endcase

        if (~&byte_pos)
            byte_pos = byte_pos + 1'b1;

        if (stop || req.source_end) begin
            res  = finish_walk();
            emit = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   req;
        t_result got;
        t_result want;
        logic    emit;
        if (!i_rst_n) begin
            span_limit = MAX_SPAN_RST;
            walk_phase = PH_IDLE;
            walk_results_q.delete();
        end else begin
            if (i_cfg_we)
                span_limit = i_cfg_wdata;

            if (i_res_mon.valid && i_res_mon.ready) begin
                got.found         = i_res_mon.found;
                got.carved_length = i_res_mon.carved_length;
                got.page_count    = i_res_mon.page_count;
                result_total++;
                if (walk_results_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with nothing expected: found %0d length %0d pages %0d",
                             $time, got.found, got.carved_length, got.page_count);
                end else begin
                    want = walk_results_q.pop_front();
                    if (got.found !== want.found) begin
                        fail_total++;
                        $display("%0t: found mismatch, expected %0d actual %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.carved_length !== want.carved_length) begin
                        fail_total++;
                        $display("%0t: carved_length mismatch, expected %0d actual %0d",
                                 $time, want.carved_length, got.carved_length);
                    end
                    if (got.page_count !== want.page_count) begin
                        fail_total++;
                        $display("%0t: page_count mismatch, expected %0d actual %0d",
                                 $time, want.page_count, got.page_count);
                    end
                    if (want.found)
                        found_total++;
                end
            end

            if (i_req_mon.valid && i_req_mon.ready) begin
                req.data_byte  = i_req_mon.data_byte;
                req.first_byte = i_req_mon.first_byte;
                req.source_end = i_req_mon.source_end;
                step_walker(req, emit, want);
                if (emit)
                    expect_result(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= walk_results_q.size();
        o_results    <= result_total;
        o_found      <= found_total;
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the Ogg page chain walker: drives page chains with random
// content, breaks and truncations, under several span settings.
// ----------------------------------------------------------------------------
module tb;
    import ogpw_pkg::*;

    // Small page limit so that the limit stop is reachable in a short run.
    localparam int unsigned PAGE_LIMIT   = 5;
    localparam int          PHASE_BYTES  = 100;
    localparam int          ITEM_GOAL    = 1850;
    localparam int          DRAIN_TAIL   = 4;       // input and result registers plus margin
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SPAN_PHASES  = 8;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [SPAN_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int results;
    int found_cnt;

    ogpw_in_if  in_ch ();
    ogpw_out_if out_ch ();

    ogg_page_chain_walker_unit #(
        .MAX_PAGES (PAGE_LIMIT)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    ogpw_chain_checker #(
        .PAGE_LIMIT (PAGE_LIMIT)
    ) chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req_mon    (in_ch),
        .i_res_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_found      (found_cnt)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stimulus bookkeeping
    logic [7:0]        chain_q[$];     // bytes of the walk being built
    int                page_at[$];     // offset of each page header in chain_q
    logic [SPAN_W-1:0] span_plan [SPAN_PHASES];
    logic [SPAN_W-1:0] cur_span;
    int                src_run = 0;    // remaining requests with no gap
    int                snk_run = 0;    // remaining results with no stall
    int                sent_total = 0;
    int                walk_bytes = 0;
    int                cycle_cnt = 0;

    function automatic void add_byte(input logic [7:0] b);
        chain_q.insert(chain_q.size(), b);
    endfunction

    // Wait draw returns 0..15. Now and then a stretch of back-to-back
    // requests so that the block also sees full rate.
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(10, 40);
            return 0;
        end
        return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 15);
    endfunction

    // One byte request. valid only drops when a gap is drawn, so a
    // back-to-back request never sees valid lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last_b);
        int gap;
        gap = draw_wait(src_run);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= first;
        in_ch.source_end <= last_b;
        do @(posedge clk); while (!in_ch.ready);
        sent_total++;
    endtask

    // Hold off the sender until every predicted result is out, then let the
    // walker settle: a walk that gives no result may still be in flight.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_span(input logic [SPAN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_span  = value;
    endtask

    // Well-formed chain: "OggS", version 0, random header body, segment
    // count, lacing table and random payload. Mostly short pages; some with
    // empty payloads, full 255-entry tables or 255-byte lacing values.
    task automatic build_chain(input int n_pages);
        int nseg;
        int lace;
        int pay;
        int k;
        int s;
        chain_q.delete();
        page_at.delete();
        for (k = 0; k < n_pages; k++) begin
            page_at.insert(page_at.size(), chain_q.size());
            add_byte(CHR_O);
            add_byte(CHR_G);
            add_byte(CHR_G);
            add_byte(CHR_S);
            add_byte(VERSION_0);
            repeat (HDR_LAST - MAGIC_LEN) add_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 15))
                0, 1:    nseg = 0;
                2:       nseg = 255;
                default: nseg = $urandom_range(1, 6);
            endcase
            add_byte(8'(nseg));
            pay = 0;
            for (s = 0; s < nseg; s++) begin
                if (nseg == 255) begin
                    lace = $urandom_range(0, 1);
                end else begin
                    case ($urandom_range(0, 15))
                        0:       lace = 255;
                        1, 2:    lace = 0;
                        default: lace = $urandom_range(1, 12);
                    endcase
                end
                add_byte(8'(lace));
                pay += lace;
            end
            repeat (pay) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // One walk: a chain sent whole, truncated, broken in a magic byte,
    // abandoned by a restart, or left open. Sometimes trailed by stray bytes.
    task automatic run_walk();
        int   n_pages;
        int   cut;
        int   idx;
        int   pick;
        logic ends;
        if ($urandom_range(0, 5) == 0)
            n_pages = $urandom_range(PAGE_LIMIT, PAGE_LIMIT + 2);
        else
            n_pages = $urandom_range(1, 3);
        build_chain(n_pages);
        cut  = chain_q.size();
        ends = 1'b1;
        case ($urandom_range(0, 9))
            5: cut = $urandom_range(1, chain_q.size());
            6: begin
                // flip bits of one signature or version byte
                idx = page_at[$urandom_range(0, page_at.size() - 1)]
                      + $urandom_range(0, MAGIC_LEN - 1);
                chain_q[idx] = chain_q[idx] ^ 8'($urandom_range(1, 255));
                cut = idx + 1 + $urandom_range(0, 2);
                if (cut > chain_q.size())
                    cut = chain_q.size();
                ends = 1'($urandom_range(0, 1));
            end
            7: begin
                // next walk's first byte abandons this one
                cut  = $urandom_range(1, chain_q.size());
                ends = 1'b0;
            end
            8: ends = 1'b0;
            default: ;
        endcase
        // span below one header: the first byte already ends the walk
        if (cur_span < HDR_LEN && cut > 3)
            cut = $urandom_range(1, 3);
        for (pick = 0; pick < cut; pick++)
            send_byte(chain_q[pick], pick == 0, ends && pick == cut - 1);
        walk_bytes += cut;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    // Result side: random stall per result, with no-stall stretches.
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(snk_run);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
        $display("** ogg_page_chain_walker_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int walks;
        int phase_start;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'd0;
        in_ch.first_byte <= 1'b0;
        in_ch.source_end <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        rst_n            <= 1'b0;
        cur_span          = MAX_SPAN_RST;

        span_plan[0] = MAX_SPAN_RST;
        span_plan[1] = '1;                               // largest span
        span_plan[2] = SPAN_W'(HDR_LEN);                 // room for one bare header
        span_plan[3] = SPAN_W'($urandom_range(HDR_LEN + 1, 400));
        span_plan[4] = '0;
        span_plan[5] = SPAN_W'($urandom_range(400, 3000));
        span_plan[6] = SPAN_W'(HDR_LEN - 1);             // one short of a header
        span_plan[7] = MAX_SPAN_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // bytes outside a walk are dropped, source_end or not
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        drain();
        // zero span: every first byte reports an empty walk at once
        write_span('0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(CHR_O, 1'b1, 1'b1);
        drain();
        write_span(SPAN_W'(HDR_LEN - 1));
        send_byte(CHR_O, 1'b1, 1'b1);
        drain();
        write_span(MAX_SPAN_RST);
        // mismatch on the very first byte
        send_byte(8'h00, 1'b1, 1'b0);
        // good signature, bad version
        send_byte(CHR_O, 1'b1, 1'b0);
        send_byte(CHR_G, 1'b0, 1'b0);
        send_byte(CHR_G, 1'b0, 1'b0);
        send_byte(CHR_S, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        // restart inside a header, then a source end with no page
        send_byte(CHR_O, 1'b1, 1'b0);
        send_byte(CHR_G, 1'b0, 1'b0);
        send_byte(CHR_O, 1'b1, 1'b0);
        send_byte(CHR_G, 1'b0, 1'b1);
        // one-byte source
        send_byte(CHR_O, 1'b1, 1'b1);

        // --- random walks, one span setting per phase ---
        for (ph = 0; ph < SPAN_PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                write_span(span_plan[ph]);
            end
            walks       = 0;
            phase_start = walk_bytes;
            while ((cur_span < HDR_LEN) ? (walks < 12) : (walk_bytes - phase_start < PHASE_BYTES))
            begin
                run_walk();
                walks++;
                // mid-phase pause until the result side has caught up
                if ($urandom_range(0, 15) == 0)
                    drain();
            end
        end
        // keep going at the reset span until enough bytes
        while (walk_bytes < ITEM_GOAL)
            run_walk();

        drain();
        $display("%0d byte requests (%0d inside walks), %0d results checked, %0d with pages",
                 sent_total, walk_bytes, results, found_cnt);
        $display("spans 0, 26, 27, %0d, %0d, 2^32 and 2^33-1; page limit %0d",
                 span_plan[3], span_plan[5], PAGE_LIMIT);
        if (fail_count == 0 && pending == 0)
            $display("** ogg_page_chain_walker_unit: PASSED **");
        else
            $display("** ogg_page_chain_walker_unit: FAILED **");
        $finish;
    end

endmodule
